// File: hw/rtl/fdcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcp_pkg
// Shared types, constants and lookup functions of the framed decimal
// command parser: frame markers, number limits and the fraction scaling
// reciprocals.
// ----------------------------------------------------------------------------
package fdcp_pkg;

   localparam int MARK_LEN         = 9;
   localparam int NUM_CHARS_MAX    = 31;
   localparam int FRAC_DIGITS_KEPT = 5;
   localparam int FRAC_BITS        = 16;
   localparam int FIELD_COUNT_MAX  = 7;
   localparam int FIELDS_STORED    = 4;
   localparam int INT_SAT          = 32767;
   localparam int FRAC_LIMIT       = 100000;

   localparam logic [7:0] CHR_COMMA = 8'h2C;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_DOT   = 8'h2E;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;
   localparam logic [7:0] CHR_CLOSE = 8'h7D;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_DATA    = 2'd1,
      PH_TRAILER = 2'd2,
      PH_DONE    = 2'd3
   } phase_type;

   // "CSharpST{"
   function automatic logic [7:0] head_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = 8'h43;
         4'd1:    c = 8'h53;
         4'd2:    c = 8'h68;
         4'd3:    c = 8'h61;
         4'd4:    c = 8'h72;
         4'd5:    c = 8'h70;
         4'd6:    c = 8'h53;
         4'd7:    c = 8'h54;
         4'd8:    c = 8'h7B;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // "}CSharpED"
   function automatic logic [7:0] tail_char(input logic [3:0] pos);
      logic [7:0] c;
      case (pos)
         4'd0:    c = 8'h7D;
         4'd1:    c = 8'h43;
         4'd2:    c = 8'h53;
         4'd3:    c = 8'h68;
         4'd4:    c = 8'h61;
         4'd5:    c = 8'h72;
         4'd6:    c = 8'h70;
         4'd7:    c = 8'h45;
         4'd8:    c = 8'h44;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // ceil(2^s / (2 * 5^k)) for k kept fraction digits; exact for 30-bit dividends
   function automatic logic [30:0] frac_recip(input logic [2:0] k);
      logic [30:0] m;
      case (k)
         3'd1:    m = 31'd1717986919;  // s = 34
         3'd2:    m = 31'd1374389535;  // s = 36
         3'd3:    m = 31'd1099511628;  // s = 38
         3'd4:    m = 31'd1759218605;  // s = 41
         3'd5:    m = 31'd1407374884;  // s = 43
         default: m = 31'd0;
      endcase
      return m;
   endfunction

endpackage

// File: hw/rtl/framed_decimal_command_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_decimal_command_parser_top
// Byte stream parser for frames "CSharpST{a,b,c,d,e}CSharpED": converts the
// five decimal fields to signed Q16.16 and sends them as one beat.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------------
//  req_    | in  | one received byte
//  rsp_   | out | five Q16.16 values, one beat per five-field frame, sent at its closing brace
//
//  One byte per cycle while the result register is free: a byte is held in the
//  input register, and the parser state and the result register update from it.
//  Critical path: fraction scaling multiplier (30 x 31) into the result.
//  Reset clears the parser and the four stored fields.
//  A stalled result beat holds the input register; a byte keeps moving while
//  the result register is empty or being taken in the same cycle.
// ----------------------------------------------------------------------------
module framed_decimal_command_parser_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata    // left_track, right_track, turret_h,
                                     // turret_v, fire_power (32 bits each)
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // parser state
   fdcp_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  marker_pos_ff, marker_pos_in;
   logic [2:0]  field_count_ff, field_count_in;
   logic [4:0]  char_count_ff, char_count_in;
   logic        num_negative_ff, num_negative_in;
   logic        num_in_fraction_ff, num_in_fraction_in;
   logic        num_stopped_ff, num_stopped_in;
   logic [14:0] int_part_ff, int_part_in;
   logic [16:0] frac_part_ff, frac_part_in;
   logic [2:0]  frac_digits_ff, frac_digits_in;
   logic [31:0] stored_ff [fdcp_pkg::FIELDS_STORED];

   // result register
   logic         out_valid_ff, out_valid_in;
   logic [159:0] out_data_ff;

   logic        out_free;
   logic        advance;
   logic        emit;
   logic        store_en;
   logic        is_num_char;
   logic [3:0]  digit;
   logic [18:0] int_next;
   logic [20:0] frac_next;
   logic [2:0]  field_bump;

   logic [29:0] frac_num;
   logic [60:0] frac_prod;
   logic [15:0] frac_q;
   logic [30:0] mag;
   logic [31:0] num_value;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // ---------------------------------------------------------------- number value
   // round(frac * 2^16 / 10^k) = floor((frac * 2^(17-k) + 5^k) / (2 * 5^k))
   always_comb begin
      case (frac_digits_ff)
         3'd1:    frac_num = (30'(frac_part_ff) << 16) + 30'd5;
         3'd2:    frac_num = (30'(frac_part_ff) << 15) + 30'd25;
         3'd3:    frac_num = (30'(frac_part_ff) << 14) + 30'd125;
         3'd4:    frac_num = (30'(frac_part_ff) << 13) + 30'd625;
         3'd5:    frac_num = (30'(frac_part_ff) << 12) + 30'd3125;
         default: frac_num = 30'd0;
      endcase
   end

   assign frac_prod = 61'(frac_num) * 61'(fdcp_pkg::frac_recip(frac_digits_ff));

   always_comb begin
      case (frac_digits_ff)
         3'd1:    frac_q = frac_prod[49:34];
         3'd2:    frac_q = frac_prod[51:36];
         3'd3:    frac_q = frac_prod[53:38];
         3'd4:    frac_q = frac_prod[56:41];
         3'd5:    frac_q = frac_prod[58:43];
         default: frac_q = 16'd0;
      endcase
   end

   // int_part tops out at 32767, so the magnitude never exceeds 2^31 - 1
   assign mag       = {int_part_ff, frac_q};
   assign num_value = num_negative_ff ? (32'd0 - {1'b0, mag}) : {1'b0, mag};

   // ---------------------------------------------------------------- byte decode
   assign is_num_char = (in_byte_ff inside {[fdcp_pkg::CHR_ZERO:fdcp_pkg::CHR_NINE]}) ||
                        in_byte_ff == fdcp_pkg::CHR_DOT || in_byte_ff == fdcp_pkg::CHR_MINUS;
   assign digit      = 4'(in_byte_ff - fdcp_pkg::CHR_ZERO);
   assign int_next   = ({1'b0, int_part_ff, 3'b000} + {3'b000, int_part_ff, 1'b0}) +
                       19'(digit);
   assign frac_next  = ({1'b0, frac_part_ff, 3'b000} + {3'b000, frac_part_ff, 1'b0}) +
                       21'(digit);
   assign field_bump = (field_count_ff == 3'(fdcp_pkg::FIELD_COUNT_MAX)) ?
                       field_count_ff : field_count_ff + 3'd1;

   // ---------------------------------------------------------------- next state
   always_comb begin
      phase_in           = phase_ff;
      marker_pos_in      = marker_pos_ff;
      field_count_in     = field_count_ff;
      char_count_in      = char_count_ff;
      num_negative_in    = num_negative_ff;
      num_in_fraction_in = num_in_fraction_ff;
      num_stopped_in     = num_stopped_ff;
      int_part_in        = int_part_ff;
      frac_part_in       = frac_part_ff;
      frac_digits_in     = frac_digits_ff;

      if (advance) begin
         case (phase_ff)
            fdcp_pkg::PH_HEADER: begin
               if (marker_pos_ff < 4'(fdcp_pkg::MARK_LEN) &&
                   in_byte_ff == fdcp_pkg::head_char(marker_pos_ff)) begin
                  if (marker_pos_ff == 4'(fdcp_pkg::MARK_LEN - 1)) begin
                     phase_in           = fdcp_pkg::PH_DATA;
                     marker_pos_in      = 4'd0;
                     field_count_in     = 3'd0;
                     char_count_in      = 5'd0;
                     num_negative_in    = 1'b0;
                     num_in_fraction_in = 1'b0;
                     num_stopped_in     = 1'b0;
                     int_part_in        = 15'd0;
                     frac_part_in       = 17'd0;
                     frac_digits_in     = 3'd0;
                  end else begin
                     marker_pos_in = marker_pos_ff + 4'd1;
                  end
               end else begin
                  marker_pos_in = 4'd0;
               end
            end

            fdcp_pkg::PH_DATA: begin
               if (in_byte_ff == fdcp_pkg::CHR_CLOSE) begin
                  phase_in      = fdcp_pkg::PH_TRAILER;
                  marker_pos_in = 4'd1;
               end else if (in_byte_ff == fdcp_pkg::CHR_COMMA ||
                            (is_num_char &&
                             char_count_ff == 5'(fdcp_pkg::NUM_CHARS_MAX))) begin
                  // end of field, or over-long number (dropped): clear the number and count a field
                  field_count_in     = field_bump;
                  char_count_in      = 5'd0;
                  num_negative_in    = 1'b0;
                  num_in_fraction_in = 1'b0;
                  num_stopped_in     = 1'b0;
                  int_part_in        = 15'd0;
                  frac_part_in       = 17'd0;
                  frac_digits_in     = 3'd0;
               end else if (is_num_char) begin
                  char_count_in = char_count_ff + 5'd1;
                  if (!num_stopped_ff) begin
                     if (in_byte_ff == fdcp_pkg::CHR_MINUS) begin
                        if (char_count_ff == 5'd0) num_negative_in = 1'b1;
                        else                       num_stopped_in  = 1'b1;
                     end else if (in_byte_ff == fdcp_pkg::CHR_DOT) begin
                        if (num_in_fraction_ff) num_stopped_in     = 1'b1;
                        else                    num_in_fraction_in = 1'b1;
                     end else if (!num_in_fraction_ff) begin
                        int_part_in = (int_next > 19'(fdcp_pkg::INT_SAT)) ?
                                      15'(fdcp_pkg::INT_SAT) : int_next[14:0];
                     end else if (frac_digits_ff < 3'(fdcp_pkg::FRAC_DIGITS_KEPT)) begin
                        frac_part_in   = frac_next[16:0];
                        frac_digits_in = frac_digits_ff + 3'd1;
                     end
                  end
               end
            end

            fdcp_pkg::PH_TRAILER: begin
               if (marker_pos_ff < 4'(fdcp_pkg::MARK_LEN) &&
                   in_byte_ff == fdcp_pkg::tail_char(marker_pos_ff)) begin
                  marker_pos_in = marker_pos_ff + 4'd1;
                  if (marker_pos_ff == 4'(fdcp_pkg::MARK_LEN - 1)) begin
                     phase_in = fdcp_pkg::PH_DONE;
                  end
               end else begin
                  phase_in           = fdcp_pkg::PH_HEADER;
                  marker_pos_in      = 4'd0;
                  field_count_in     = 3'd0;
                  char_count_in      = 5'd0;
                  num_negative_in    = 1'b0;
                  num_in_fraction_in = 1'b0;
                  num_stopped_in     = 1'b0;
                  int_part_in        = 15'd0;
                  frac_part_in       = 17'd0;
                  frac_digits_in     = 3'd0;
               end
            end

            default: begin
               // idle after a frame: the first header byte restarts the match
               if (in_byte_ff == fdcp_pkg::head_char(4'd0)) begin
                  phase_in           = fdcp_pkg::PH_HEADER;
                  marker_pos_in      = 4'd1;
                  field_count_in     = 3'd0;
                  char_count_in      = 5'd0;
                  num_negative_in    = 1'b0;
                  num_in_fraction_in = 1'b0;
                  num_stopped_in     = 1'b0;
                  int_part_in        = 15'd0;
                  frac_part_in       = 17'd0;
                  frac_digits_in     = 3'd0;
               end
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      emit     = 1'b0;
      store_en = 1'b0;
      case (phase_ff)
         fdcp_pkg::PH_DATA: begin
            emit     = advance && in_byte_ff == fdcp_pkg::CHR_CLOSE &&
                       field_count_ff == 3'(fdcp_pkg::FIELDS_STORED);
            store_en = advance && in_byte_ff == fdcp_pkg::CHR_COMMA &&
                       field_count_ff < 3'(fdcp_pkg::FIELDS_STORED);
         end
         default: begin
            emit     = 1'b0;
            store_en = 1'b0;
         end
      endcase
   end

   assign out_valid_in = emit || (out_valid_ff && !rsp_tready);

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         phase_ff           <= fdcp_pkg::PH_HEADER;
         marker_pos_ff      <= 4'd0;
         field_count_ff     <= 3'd0;
         char_count_ff      <= 5'd0;
         num_negative_ff    <= 1'b0;
         num_in_fraction_ff <= 1'b0;
         num_stopped_ff     <= 1'b0;
         int_part_ff        <= 15'd0;
         frac_part_ff       <= 17'd0;
         frac_digits_ff     <= 3'd0;
         for (int i = 0; i < fdcp_pkg::FIELDS_STORED; i++) begin
            stored_ff[i] <= 32'd0;
         end
      end else begin
         in_valid_ff        <= in_valid_in;
         out_valid_ff       <= out_valid_in;
         phase_ff           <= phase_in;
         marker_pos_ff      <= marker_pos_in;
         field_count_ff     <= field_count_in;
         char_count_ff      <= char_count_in;
         num_negative_ff    <= num_negative_in;
         num_in_fraction_ff <= num_in_fraction_in;
         num_stopped_ff     <= num_stopped_in;
         int_part_ff        <= int_part_in;
         frac_part_ff       <= frac_part_in;
         frac_digits_ff     <= frac_digits_in;
         if (store_en) begin
            stored_ff[field_count_ff[1:0]] <= num_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (emit) begin
         out_data_ff <= {num_value, stored_ff[3], stored_ff[2], stored_ff[1], stored_ff[0]};
      end
   end

   // ---------------------------------------------------------------- assertions
   a_close_enters_trailer: assert property (@(posedge clock) disable iff (reset)
      advance && phase_ff == fdcp_pkg::PH_DATA && in_byte_ff == fdcp_pkg::CHR_CLOSE
      |=> phase_ff == fdcp_pkg::PH_TRAILER && marker_pos_ff == 4'd1)
      else $error("closing brace did not start trailer match");

   a_char_count_bound: assert property (@(posedge clock) disable iff (reset)
      char_count_ff <= 5'(fdcp_pkg::NUM_CHARS_MAX))
      else $error("number character count past limit");

   a_frac_bound: assert property (@(posedge clock) disable iff (reset)
      frac_digits_ff <= 3'(fdcp_pkg::FRAC_DIGITS_KEPT) &&
      frac_part_ff < 17'(fdcp_pkg::FRAC_LIMIT))
      else $error("fraction accumulator out of range");

   a_result_from_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance))
      else $error("result beat without a processed byte");

   a_no_store_and_emit: assert property (@(posedge clock) disable iff (reset)
      !(emit && store_en))
      else $error("store and emit in the same cycle");

endmodule

// File: bench/framed_decimal_command_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_decimal_command_parser_top_tb
// Drives byte streams into the command parser: a directed set of frames
// first, then random frames with random number text, noise and broken
// markers. A scoreboard class predicts each five-field command beat.
// Both sides of the stream idle at random, and the receiver holds off once
// long enough for the parser to stall its input.
// ----------------------------------------------------------------------------
module framed_decimal_command_parser_top_tb;

   localparam int HOLD_OFF_CYCLES = 600;
   localparam int DRAIN_CYCLES    = 20;
   localparam int RANDOM_BYTES    = 2000;
   localparam int TIMEOUT_NS      = 2000000;
   localparam int REPORT_LIMIT    = 10;

   class command_scoreboard;
      localparam logic [71:0] HEAD_TEXT = "CSharpST{";
      localparam logic [71:0] TAIL_TEXT = "}CSharpED";

      fdcp_pkg::phase_type phase;
      int           marker_pos;
      int           field_count;
      int           char_count;
      bit           negative;
      bit           in_fraction;
      bit           stopped;
      int unsigned  int_part;
      int unsigned  frac_part;
      int unsigned  frac_digits;
      logic [31:0]  stored [fdcp_pkg::FIELDS_STORED];
      logic [159:0] pending_commands [$];
      string        field_name [5];
      int           failures;

      function new();
         restart_parser();
         foreach (stored[i]) stored[i] = '0;
         field_name = '{"left_track", "right_track", "turret_h", "turret_v", "fire_power"};
         failures = 0;
      endfunction

      function void clear_number();
         char_count  = 0;
         negative    = 1'b0;
         in_fraction = 1'b0;
         stopped     = 1'b0;
         int_part    = 0;
         frac_part   = 0;
         frac_digits = 0;
      endfunction

      function void restart_parser();
         phase       = fdcp_pkg::PH_HEADER;
         marker_pos  = 0;
         field_count = 0;
         clear_number();
      endfunction

      function void bump_fields();
         if (field_count < fdcp_pkg::FIELD_COUNT_MAX) field_count++;
      endfunction

      function void take_char(logic [7:0] c);
         int pos;
         pos = char_count;
         char_count++;
         if (stopped) return;
         if (c == fdcp_pkg::CHR_MINUS) begin
            if (pos == 0) negative = 1'b1;
            else stopped = 1'b1;
         end else if (c == fdcp_pkg::CHR_DOT) begin
            if (in_fraction) stopped = 1'b1;
            else in_fraction = 1'b1;
         end else if (!in_fraction) begin
            int_part = int_part * 10 + (c - fdcp_pkg::CHR_ZERO);
            if (int_part > fdcp_pkg::INT_SAT) int_part = fdcp_pkg::INT_SAT;
         end else if (frac_digits < fdcp_pkg::FRAC_DIGITS_KEPT) begin
            frac_part = frac_part * 10 + (c - fdcp_pkg::CHR_ZERO);
            frac_digits++;
         end
      endfunction

      // round the kept fraction to FRAC_BITS bits, ties away from zero
      function logic [31:0] number_q16();
         logic [63:0] divisor;
         logic [63:0] scaled;
         logic [63:0] magnitude;
         divisor = 64'd1;
         for (int i = 0; i < frac_digits; i++) divisor = divisor * 10;
         scaled    = ((64'(frac_part) << fdcp_pkg::FRAC_BITS) + divisor / 2) / divisor;
         magnitude = (64'(int_part) << fdcp_pkg::FRAC_BITS) + scaled;
         if (magnitude > 64'h7FFF_FFFF) magnitude = 64'h7FFF_FFFF;
         return negative ? 32'd0 - magnitude[31:0] : magnitude[31:0];
      endfunction

      function void note_byte(logic [7:0] c);
         case (phase)
            fdcp_pkg::PH_HEADER: begin
               if (c == HEAD_TEXT[8*(fdcp_pkg::MARK_LEN-1-marker_pos) +: 8]) begin
                  marker_pos++;
                  if (marker_pos == fdcp_pkg::MARK_LEN) begin
                     phase       = fdcp_pkg::PH_DATA;
                     marker_pos  = 0;
                     field_count = 0;
                     clear_number();
                  end
               end else begin
                  marker_pos = 0;
               end
            end
            fdcp_pkg::PH_DATA: begin
               if (c == fdcp_pkg::CHR_CLOSE) begin
                  if (field_count == fdcp_pkg::FIELDS_STORED) begin
                     pending_commands.push_back({number_q16(), stored[3], stored[2],
                                                 stored[1], stored[0]});
                  end
                  phase      = fdcp_pkg::PH_TRAILER;
                  marker_pos = 1;
               end else if (c == fdcp_pkg::CHR_COMMA) begin
                  if (field_count < fdcp_pkg::FIELDS_STORED)
                     stored[field_count] = number_q16();
                  bump_fields();
                  clear_number();
               end else if ((c >= fdcp_pkg::CHR_ZERO && c <= fdcp_pkg::CHR_NINE) ||
                            c == fdcp_pkg::CHR_DOT || c == fdcp_pkg::CHR_MINUS) begin
                  // drop the whole number once it runs past the length limit
                  if (char_count < fdcp_pkg::NUM_CHARS_MAX) begin
                     take_char(c);
                  end else begin
                     clear_number();
                     bump_fields();
                  end
               end
            end
            fdcp_pkg::PH_TRAILER: begin
               if (c == TAIL_TEXT[8*(fdcp_pkg::MARK_LEN-1-marker_pos) +: 8]) begin
                  marker_pos++;
                  if (marker_pos == fdcp_pkg::MARK_LEN) phase = fdcp_pkg::PH_DONE;
               end else begin
                  restart_parser();
               end
            end
            default: begin
               if (c == HEAD_TEXT[71 -: 8]) begin
                  restart_parser();
                  marker_pos = 1;
               end
            end
         endcase
      endfunction

      function void check_command(logic [159:0] got);
         logic [159:0] want;
         if (pending_commands.size() == 0) begin
            if (failures < REPORT_LIMIT)
               $display("%0t: unexpected command beat %h", $time, got);
            failures++;
            return;
         end
         want = pending_commands.pop_front();
         for (int i = 0; i < 5; i++) begin
            if (got[32*i +: 32] !== want[32*i +: 32]) begin
               if (failures < REPORT_LIMIT)
                  $display("%0t: %s expected %h, got %h", $time, field_name[i],
                           want[32*i +: 32], got[32*i +: 32]);
               failures++;
            end
         end
      endfunction
   endclass

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = 8'h00;   // [7:0] rx_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;            // left_track, right_track, turret_h,
                                       // turret_v, fire_power (32 bits each)

   command_scoreboard sb;
   logic [7:0] tx_bytes [$];
   bit         steady;
   bit         hold_off_req;
   int         bytes_sent;

   framed_decimal_command_parser_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // handshake is judged mid-cycle, where nothing moves
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(negedge clock); while (!req_tready);
      sb.note_byte(b);
      bytes_sent++;
      @(posedge clock);
   endtask

   task automatic send_queue();
      while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
   endtask

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
   endfunction

   function automatic void add_digits(int n);
      repeat (n) tx_bytes.push_back(fdcp_pkg::CHR_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void add_noise_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == fdcp_pkg::CHR_COMMA || b == fdcp_pkg::CHR_CLOSE);
      tx_bytes.push_back(b);
   endfunction

   function automatic void add_number();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 10) return;
      if ($urandom_range(0, 3) == 0) tx_bytes.push_back(fdcp_pkg::CHR_MINUS);
      if (kind < 45) begin
         add_digits($urandom_range(0, 3));
         if ($urandom_range(0, 1) == 1) begin
            tx_bytes.push_back(fdcp_pkg::CHR_DOT);
            add_digits($urandom_range(0, 7));
         end
      end else if (kind < 60) begin
         // large integers can run into saturation
         add_digits($urandom_range(5, 9));
         tx_bytes.push_back(fdcp_pkg::CHR_DOT);
         add_digits(5);
      end else if (kind < 72) begin
         repeat ($urandom_range(2, 8)) begin
            if ($urandom_range(0, 1) == 1) add_digits(1);
            else add_noise_byte();
         end
      end else if (kind < 82) begin
         // a second dot or a late minus stops the number
         add_digits($urandom_range(1, 3));
         tx_bytes.push_back(($urandom_range(0, 1) == 1) ? fdcp_pkg::CHR_DOT :
                                                          fdcp_pkg::CHR_MINUS);
         add_digits($urandom_range(0, 2));
         tx_bytes.push_back(($urandom_range(0, 1) == 1) ? fdcp_pkg::CHR_DOT :
                                                          fdcp_pkg::CHR_MINUS);
         add_digits($urandom_range(0, 2));
      end else if (kind < 90) begin
         add_digits($urandom_range(29, 40));
      end else begin
         add_digits(1);
         tx_bytes.push_back(fdcp_pkg::CHR_DOT);
         add_digits(5);
      end
   endfunction

   function automatic void add_frame();
      string text;
      int    cut;
      int    fields;
      int    bad;
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 5)) tx_bytes.push_back(8'($urandom_range(0, 255)));
      text = "CSharpST{";
      if ($urandom_range(0, 7) == 0) begin
         cut = $urandom_range(1, 8);
         for (int i = 0; i < cut; i++) tx_bytes.push_back(text[i]);
         tx_bytes.push_back(8'($urandom_range(0, 255)));
      end
      add_text(text);
      fields = ($urandom_range(0, 3) != 0) ? 5 : $urandom_range(1, 8);
      for (int i = 0; i < fields; i++) begin
         add_number();
         if (i < fields - 1) tx_bytes.push_back(fdcp_pkg::CHR_COMMA);
      end
      tx_bytes.push_back(fdcp_pkg::CHR_CLOSE);
      text = "CSharpED";
      bad  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : 8;
      for (int i = 0; i < 8; i++)
         tx_bytes.push_back((i == bad) ? 8'($urandom_range(0, 255)) : text[i]);
      if ($urandom_range(0, 9) < 3)
         repeat ($urandom_range(1, 4)) tx_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   initial begin : rsp_side
      int r;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            for (int held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clock);
         end else if (steady) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            rsp_tready <= (r < 65);
            if (r < 65) repeat ($urandom_range(1, 8)) @(posedge clock);
            else if (r < 95) repeat ($urandom_range(1, 3)) @(posedge clock);
            else repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_command(rsp_tdata);
   end

   initial begin
      #(TIMEOUT_NS);
      $display("framed_decimal_command_parser_top_tb failed");
      $finish;
   end

   initial begin : stimulus
      int random_start;
      int frame_index;
      sb = new();
      bytes_sent   = 0;
      steady       = 1'b0;
      hold_off_req = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      add_text("CSharpST{1,2,3,4,5}CSharpED");
      add_text("CSharpST{-0.5,32767.99999,123456789.1234567,-0,.00001}CSharpED");
      // the second C is not matched again, so this header is missed
      add_text("CCSharpST{9,9,9,9,9}CSharpED");
      add_text("CSharpSCSharpST{,,,,}CSharpED");
      add_text("CSharpST{1.2.3,4-5,--6,7x 8,-.5}CSharpED");
      add_text("CSharpST{1,2,3,4,5,6,7,8,9}CSharpED");
      add_text("CSharpST{1,2,3}CSharpED");
      add_text("CSharpST{1,2,3,4,5}CSharpEX7,8}");
      // over-long first field: stored field 0 keeps its old value
      add_text("zz}CSharpST{11111111111111111111111111111111,2,3,4}CSharpEDxC");
      add_text("SharpST{0000000000000000000000000000001,32767,-32767.99999,1");
      tx_bytes.push_back(8'h00);
      tx_bytes.push_back(8'hFF);
      add_text(",0.00005}CSharpED");
      tx_bytes.push_back(8'hFF);
      tx_bytes.push_back(8'h00);
      add_text("CSharpST{-1,-2,-3,-4,-32768.5}CSharpED");
      send_queue();

      random_start = bytes_sent;
      frame_index  = 0;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         steady = ($urandom_range(0, 4) == 0);
         if (frame_index == 6) begin
            // hold the receiver off while full frames keep coming
            steady       = 1'b0;
            hold_off_req = 1'b1;
            repeat (4) add_text("CSharpST{12.5,-3,0.25,7,-99.125}CSharpED");
         end else begin
            add_frame();
         end
         send_queue();
         frame_index++;
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.pending_commands.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending_commands.size() == 0)
         $display("framed_decimal_command_parser_top_tb passed");
      else
         $display("framed_decimal_command_parser_top_tb failed");
      $finish;
   end

endmodule
